// ===== rtl/erg_pkg.sv =====
// erg_pkg: shared widths, codes and request types for the eased ramp generator.
// Used by erg_mul, erg_div, the top level and the port checker.
package erg_pkg;

  // Field widths
  localparam int POS_W  = 14;
  localparam int TIME_W = 32;
  localparam int AMT_W  = 24;
  localparam int CODE_W = 2;

  // Clamp limits
  localparam logic [POS_W-1:0] POS_MAX    = 14'd9999;
  localparam logic [AMT_W-1:0] AMOUNT_MAX = 24'd9999999;

  // Q1.16 fraction handling
  localparam int Q_FRAC = 16;
  localparam int FRAC_W = Q_FRAC + 1;
  localparam logic [FRAC_W-1:0] Q_ONE  = 17'h10000;
  localparam logic [FRAC_W-1:0] Q_HALF = 17'h08000;

  // Item modes
  localparam logic [CODE_W-1:0] MODE_SET    = 2'd0;
  localparam logic [CODE_W-1:0] MODE_STOP   = 2'd1;
  localparam logic [CODE_W-1:0] MODE_SAMPLE = 2'd2;

  // Ramp kinds
  localparam logic [CODE_W-1:0] KIND_PLAIN    = 2'd0;
  localparam logic [CODE_W-1:0] KIND_SPEED    = 2'd1;
  localparam logic [CODE_W-1:0] KIND_INTERVAL = 2'd2;

  // Easing curves
  localparam logic [CODE_W-1:0] EASE_LINEAR = 2'd0;
  localparam logic [CODE_W-1:0] EASE_IN     = 2'd1;
  localparam logic [CODE_W-1:0] EASE_OUT    = 2'd2;
  localparam logic [CODE_W-1:0] EASE_IN_OUT = 2'd3;

  // Digit-serial multiplier: A x B, B consumed MUL_DW bits per cycle
  localparam int MUL_AW = 32;
  localparam int MUL_BW = 20;
  localparam int MUL_DW = 4;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Bit-serial divider: NUM / DEN, one quotient bit per cycle
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;
  localparam int DIV_QW = 20;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

endpackage

// ===== rtl/erg_mul.sv =====
// erg_mul: digit-serial unsigned multiplier, MSB digit of B first.
// Depends on erg_pkg for widths and the request struct.
module erg_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  erg_pkg::mul_req_t         req,
  output logic                      done,
  output logic [erg_pkg::MUL_PW-1:0] prod
);
  import erg_pkg::*;

  localparam int STEPS = MUL_BW / MUL_DW;
  localparam int CW    = $clog2(STEPS + 1);

  logic [MUL_AW-1:0]        a_r;
  logic [MUL_BW-1:0]        b_r;
  logic [MUL_PW-1:0]        prod_r;
  logic [CW-1:0]            cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic [MUL_DW-1:0]        dig;
  logic [MUL_AW+MUL_DW-1:0] pp;

  // one partial product per cycle
  assign dig = b_r[MUL_BW-1 -: MUL_DW];
  assign pp  = {{MUL_DW{1'b0}}, a_r} * {{MUL_AW{1'b0}}, dig};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: shift accumulator left one digit, add partial product
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r    <= req.a;
      b_r    <= req.b;
      prod_r <= '0;
    end else if (busy_r) begin
      prod_r <= {prod_r[MUL_PW-MUL_DW-1:0], {MUL_DW{1'b0}}} + MUL_PW'(pp);
      b_r    <= b_r << MUL_DW;
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// ===== rtl/erg_div.sv =====
// erg_div: restoring bit-serial divider, one quotient bit per cycle.
// Caller guarantees the quotient fits in DIV_QW bits. Depends on erg_pkg.
module erg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  erg_pkg::div_req_t         req,
  output logic                      done,
  output logic [erg_pkg::DIV_QW-1:0] quo
);
  import erg_pkg::*;

  localparam int CW = $clog2(DIV_QW + 1);

  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_QW-1:0] low_r;   // numerator bits out, quotient bits in
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  // trial subtract
  assign trial = {rem_r, low_r[DIV_QW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: upper numerator bits seed the remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.den;
      rem_r <= DIV_DW'(req.num[DIV_NW-1:DIV_QW]);
      low_r <= req.num[DIV_QW-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      low_r <= {low_r[DIV_QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = low_r;

endmodule

// ===== rtl/eased_axis_ramp_generator.sv =====
// Path from input word to out_tvalid: a plain set goes straight to the commit; outside the ramp
// the position is found first; linear uses a product and a quotient; the eased curves divide for
// f and then chain products on the shared 4-bit-digit multiplier; a speed set adds a divide on the
// bit-serial divider. One word in flight: the next is taken in the cycle after the result moves to
// the output register, which waits while an earlier result is stalled. rst_n is synchronous, active
// low: positions and stop time go to DEFAULT_POSITION; start time, last report and easing go to 0.
module eased_axis_ramp_generator #(
  parameter int unsigned DEFAULT_POSITION = 5000
) (
  input  logic        clk,
  input  logic        rst_n,
  // slave side
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // now_ms[31:0], target[45:32], ramp_amount[69:46], 0
  input  logic [3:0]  in_tuser,   // mode[1:0], ramp_kind[3:2]
  // master side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // position[13:0], changed[14], 0
  // easing_mode register
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);
  import erg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_LIN_MUL, S_LIN_DIV, S_F_DIV, S_EASE_A, S_EASE_B,
    S_EASE_C, S_EASE_D, S_EASE_G, S_APPLY, S_SPD_DIV, S_FINAL
  } state_t;

  state_t state_r;

  // latched word
  logic [CODE_W-1:0] mode_r, kind_r;
  logic [TIME_W-1:0] now_r;
  logic [POS_W-1:0]  tgt_r;
  logic [AMT_W-1:0]  amt_r;

  // ramp state
  logic [POS_W-1:0]  start_val_r, stop_val_r, last_rep_r;
  logic [TIME_W-1:0] start_time_r, stop_time_r;
  logic [CODE_W-1:0] ease_r;

  // working registers
  logic [TIME_W-1:0] dur_r;
  logic [POS_W-1:0]  mag_r, p_r;
  logic              dneg_r;
  logic [FRAC_W-1:0] f_r, inv_r, a_r, b_r, t_r;

  // output register
  logic              out_tvalid_r;
  logic [15:0]       out_data_r;

  // arithmetic units
  mul_req_t           mul_req_r;
  div_req_t           div_req_r;
  logic               mul_done, div_done;
  logic [MUL_PW-1:0]  mul_prod;
  logic [DIV_QW-1:0]  div_quo;

  erg_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req_r), .done(mul_done), .prod(mul_prod));
  erg_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req_r), .done(div_done), .quo(div_quo));

  // input clamps
  logic [POS_W-1:0] tgt_in, tgt_cl;
  logic [AMT_W-1:0] amt_in, amt_cl;
  assign tgt_in = in_tdata[45:32];
  assign amt_in = in_tdata[69:46];
  assign tgt_cl = (tgt_in > POS_MAX) ? POS_MAX : tgt_in;
  assign amt_cl = (amt_in > AMOUNT_MAX) ? AMOUNT_MAX : amt_in;

  // ramp window and span
  logic [TIME_W-1:0] elapsed_c, dur_c;
  logic              up_c, after_stop, after_start;
  logic [POS_W-1:0]  mag_c;
  assign after_stop  = now_r > stop_time_r;
  assign after_start = now_r > start_time_r;
  assign elapsed_c   = now_r - start_time_r;
  assign dur_c       = stop_time_r - start_time_r;
  assign up_c        = stop_val_r >= start_val_r;
  assign mag_c       = up_c ? (stop_val_r - start_val_r) : (start_val_r - stop_val_r);

  // Q1.16 product top bits
  logic [FRAC_W-1:0] hi_c;
  assign hi_c = mul_prod[2*Q_FRAC:Q_FRAC];

  // linear result
  logic [POS_W-1:0] lin_q, lin_pos;
  logic [POS_W:0]   lin_sum;
  assign lin_q   = div_quo[POS_W-1:0];
  assign lin_sum = {1'b0, start_val_r} + {1'b0, lin_q};
  assign lin_pos = dneg_r ? (start_val_r - lin_q)
                 : ((lin_sum > {1'b0, POS_MAX}) ? POS_MAX : lin_sum[POS_W-1:0]);

  // in-out blend, clamped to one
  logic [FRAC_W:0]   io_sum;
  logic [FRAC_W-1:0] g_io;
  assign io_sum = {1'b0, t_r} + {1'b0, hi_c};
  assign g_io   = (io_sum > {1'b0, Q_ONE}) ? Q_ONE : io_sum[FRAC_W-1:0];

  // eased result: (start*2^16 +/- g*|d| + half) >> 16, minus when descending
  logic [31:0]      ease_base, ease_s;
  logic [15:0]      ease_hi;
  logic [POS_W-1:0] ease_pos;
  assign ease_base = {2'b00, start_val_r, 16'h0000} + 32'(Q_HALF);
  assign ease_s    = dneg_r ? (ease_base - mul_prod[31:0]) : (ease_base + mul_prod[31:0]);
  assign ease_hi   = ease_s[31:16];
  assign ease_pos  = (ease_hi > 16'(POS_MAX)) ? POS_MAX : ease_hi[POS_W-1:0];

  // speed ramp: distance * 100
  logic [POS_W-1:0]  dist_c;
  logic [DIV_QW-1:0] d20, dist100;
  assign dist_c  = (tgt_r > p_r) ? (tgt_r - p_r) : (p_r - tgt_r);
  assign d20     = DIV_QW'(dist_c);
  assign dist100 = (d20 << 6) + (d20 << 5) + (d20 << 2);

  // position after the update
  logic [POS_W-1:0] fin_pos;
  assign fin_pos = after_stop ? stop_val_r : (after_start ? p_r : start_val_r);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      start_val_r     <= POS_W'(DEFAULT_POSITION);
      stop_val_r      <= POS_W'(DEFAULT_POSITION);
      start_time_r    <= '0;
      stop_time_r     <= TIME_W'(DEFAULT_POSITION);
      last_rep_r      <= '0;
      ease_r          <= EASE_LINEAR;
      out_tvalid_r    <= 1'b0;
      mul_req_r.start <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      mul_req_r.start <= 1'b0;
      div_req_r.start <= 1'b0;
      if (cfg_wr_en) begin
        ease_r <= cfg_wr_data;
      end
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r <= in_tuser[1:0];
            kind_r <= in_tuser[3:2];
            now_r  <= in_tdata[31:0];
            tgt_r  <= tgt_cl;
            amt_r  <= amt_cl;
            if (in_tuser[1:0] == MODE_SET && in_tuser[3:2] != KIND_SPEED
                && in_tuser[3:2] != KIND_INTERVAL) begin
              state_r <= S_APPLY;
            end else begin
              state_r <= S_POS;
            end
          end
        end

        // where does the current ramp stand at now
        S_POS: begin
          if (after_stop) begin
            p_r     <= stop_val_r;
            state_r <= S_APPLY;
          end else if (after_start) begin
            dur_r  <= dur_c;
            mag_r  <= mag_c;
            dneg_r <= !up_c;
            if (ease_r == EASE_LINEAR) begin
              mul_req_r <= '{start: 1'b1, a: elapsed_c, b: MUL_BW'(mag_c)};
              state_r   <= S_LIN_MUL;
            end else begin
              div_req_r <= '{start: 1'b1, num: {elapsed_c, 16'h0000}, den: dur_c};
              state_r   <= S_F_DIV;
            end
          end else begin
            p_r     <= start_val_r;
            state_r <= S_APPLY;
          end
        end

        S_LIN_MUL: begin
          if (mul_done) begin
            div_req_r <= '{start: 1'b1, num: mul_prod[DIV_NW-1:0], den: dur_r};
            state_r   <= S_LIN_DIV;
          end
        end

        S_LIN_DIV: begin
          if (div_done) begin
            p_r     <= lin_pos;
            state_r <= S_APPLY;
          end
        end

        // f = elapsed * 2^16 / duration
        S_F_DIV: begin
          if (div_done) begin
            f_r       <= div_quo[FRAC_W-1:0];
            inv_r     <= Q_ONE - div_quo[FRAC_W-1:0];
            mul_req_r <= '{start: 1'b1, a: MUL_AW'(div_quo[FRAC_W-1:0]),
                           b: MUL_BW'(div_quo[FRAC_W-1:0])};
            state_r   <= S_EASE_A;
          end
        end

        // a = f*f
        S_EASE_A: begin
          if (mul_done) begin
            a_r <= hi_c;
            if (ease_r == EASE_IN) begin
              mul_req_r <= '{start: 1'b1, a: MUL_AW'(hi_c), b: MUL_BW'(mag_r)};
              state_r   <= S_EASE_G;
            end else begin
              mul_req_r <= '{start: 1'b1, a: MUL_AW'(inv_r), b: MUL_BW'(inv_r)};
              state_r   <= S_EASE_B;
            end
          end
        end

        // b = 1 - inv*inv
        S_EASE_B: begin
          if (mul_done) begin
            b_r <= Q_ONE - hi_c;
            if (ease_r == EASE_OUT) begin
              mul_req_r <= '{start: 1'b1, a: MUL_AW'(Q_ONE - hi_c), b: MUL_BW'(mag_r)};
              state_r   <= S_EASE_G;
            end else begin
              mul_req_r <= '{start: 1'b1, a: MUL_AW'(inv_r), b: MUL_BW'(a_r)};
              state_r   <= S_EASE_C;
            end
          end
        end

        // in-out: inv*a, then f*b
        S_EASE_C: begin
          if (mul_done) begin
            t_r       <= hi_c;
            mul_req_r <= '{start: 1'b1, a: MUL_AW'(f_r), b: MUL_BW'(b_r)};
            state_r   <= S_EASE_D;
          end
        end

        S_EASE_D: begin
          if (mul_done) begin
            mul_req_r <= '{start: 1'b1, a: MUL_AW'(g_io), b: MUL_BW'(mag_r)};
            state_r   <= S_EASE_G;
          end
        end

        // g * |d| scaled onto the start position
        S_EASE_G: begin
          if (mul_done) begin
            p_r     <= ease_pos;
            state_r <= S_APPLY;
          end
        end

        // commit the command
        S_APPLY: begin
          state_r <= S_FINAL;
          case (mode_r)
            MODE_SET: begin
              start_time_r <= now_r;
              stop_val_r   <= tgt_r;
              case (kind_r)
                KIND_SPEED: begin
                  start_val_r <= p_r;
                  if (amt_r == '0) begin
                    stop_time_r <= now_r;
                  end else begin
                    div_req_r <= '{start: 1'b1, num: DIV_NW'(dist100),
                                   den: DIV_DW'(amt_r)};
                    state_r   <= S_SPD_DIV;
                  end
                end
                KIND_INTERVAL: begin
                  start_val_r <= p_r;
                  stop_time_r <= now_r + TIME_W'(amt_r);
                end
                default: begin
                  if (amt_r == '0) begin
                    stop_time_r <= now_r;
                    start_val_r <= tgt_r;
                  end
                end
              endcase
            end
            MODE_STOP: begin
              start_val_r  <= p_r;
              start_time_r <= now_r;
              stop_val_r   <= p_r;
              stop_time_r  <= now_r;
            end
            default: begin
            end
          endcase
        end

        S_SPD_DIV: begin
          if (div_done) begin
            stop_time_r <= now_r + TIME_W'(div_quo);
            state_r     <= S_FINAL;
          end
        end

        // hand the result to the output register
        S_FINAL: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= {1'b0, (fin_pos != last_rep_r), fin_pos};
            last_rep_r   <= fin_pos;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/erg_chk.sv =====
// erg_chk: port-level checker for the ramp generator, bound to the top level.
// Depends on erg_pkg for the position limit.
module erg_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  import erg_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] cnt_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[13:0] <= POS_MAX)
    else $error("position above limit");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> cnt_r != 2'd0)
    else $error("result without an input word");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("more than two words outstanding");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second word taken while one is in work");

endmodule

bind eased_axis_ramp_generator erg_chk u_erg_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
